// ===== rtl/tld_pkg.sv =====
// tld_pkg: shared constants, types and helpers of the terminal line discipline
// used by terminal_line_discipline_core and tld_decode; depends on nothing

package tld_pkg;

	localparam int BUFFER_DEPTH = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RUNNING          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_MODE        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_CR_TO_LF      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_LF_TO_CR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEL_IS_BACKSPACE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_NEWLINE_MODE = 3'd5;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [1:0] NL_NONE    = 2'd0;
	localparam logic [1:0] NL_LF_CRLF = 2'd1;
	localparam logic [1:0] NL_CR_CRLF = 2'd2;

	localparam logic DEST_SCREEN = 1'b0;
	localparam logic DEST_READER = 1'b1;

	typedef struct packed {
		logic       running;
		logic       line_mode;
		logic       in_cr_to_lf;
		logic       in_lf_to_cr;
		logic       del_is_backspace;
		logic [1:0] out_newline_mode;
	} tld_cfg_t;

	// up to three bytes emitted before any line flush
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            dest;
		logic            store;
		logic            flush;
		logic [7:0]      ch;
	} tld_echo_t;

	function automatic tld_echo_t screen_seq(input logic [7:0] c, input logic [1:0] mode);
		tld_echo_t e;
		e       = '0;
		e.dest  = DEST_SCREEN;
		e.ch    = c;
		if ((c == CH_LF && mode == NL_LF_CRLF) || (c == CH_CR && mode == NL_CR_CRLF)) begin
			e.bytes[0] = CH_CR;
			e.bytes[1] = CH_LF;
			e.cnt      = 2'd2;
		end else begin
			e.bytes[0] = c;
			e.cnt      = 2'd1;
		end
		return e;
	endfunction

endpackage

// ===== rtl/tld_in_if.sv =====
// tld_in_if: request channel into the line discipline (keypress or screen byte)
// no dependencies

interface tld_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;

	modport source (output valid, output kind, output char_byte, input ready);
	modport sink (input valid, input kind, input char_byte, output ready);
endinterface

// ===== rtl/tld_out_if.sv =====
// tld_out_if: result channel out of the line discipline
// no dependencies

interface tld_out_if;
	logic       valid;
	logic       ready;
	logic       dest;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output dest, output out_byte, output last, input ready);
	modport sink (input valid, input dest, input out_byte, input last, output ready);
endinterface

// ===== rtl/terminal_line_discipline_core.sv =====
// terminal_line_discipline_core: top level of the terminal line discipline
// depends on tld_pkg, tld_in_if, tld_out_if, tld_ram and tld_decode

// One request is taken at a time; ready is high only while the block is idle.
// While running, a screen byte or raw key yields one or two results, a line-mode echo up to three,
// one per cycle from the output register while the sink does not stall. A line flush of n
// stored characters adds n reader bytes, each read from the line ram; its registered read
// data needs the ST_FL_RD state before the first reader byte. The output register lets
// a new request be taken while the last result still waits to be accepted.
// Writing the line_mode register empties the line; the ram needs no clearing.

module terminal_line_discipline_core #(
	parameter int BUFFER_DEPTH = tld_pkg::BUFFER_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tld_in_if.sink                           item,
	tld_out_if.source                        result,
	input  logic                             cfg_wr_en,
	input  logic [tld_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tld_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ECHO,
		ST_FL_RD,
		ST_FL_WT
	} state_t;

	state_t             state_q;
	tld_pkg::tld_cfg_t  cfg_q;
	logic [AW-1:0]      fill_q;
	tld_pkg::tld_echo_t echo_q;
	logic [1:0]         idx_q;
	logic [AW-1:0]      len_q;
	logic [AW-1:0]      rd_idx_q;
	logic               out_valid_q;
	logic               dest_q;
	logic [7:0]         byte_q;
	logic               last_q;

	tld_pkg::tld_echo_t act;
	logic [AW-1:0]      fill_next;
	logic               accept;
	logic               out_free;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [7:0]         ram_rdata;
	logic               fl_last;

	tld_decode #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_decode (
		.kind      (item.kind),
		.char_byte (item.char_byte),
		.cfg       (cfg_q),
		.fill      (fill_q),
		.act       (act),
		.fill_next (fill_next)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign fl_last    = (rd_idx_q == len_q - AW'(1));

	assign ram_we    = accept && act.store;
	assign ram_re    = (state_q == ST_FL_RD) || (state_q == ST_FL_WT && out_free && !fl_last);
	assign ram_raddr = (state_q == ST_FL_RD) ? rd_idx_q : rd_idx_q + AW'(1);

	tld_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (act.ch),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign result.valid    = out_valid_q;
	assign result.dest     = dest_q;
	assign result.out_byte = byte_q;
	assign result.last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= '0;
			fill_q      <= '0;
			echo_q      <= '0;
			idx_q       <= '0;
			len_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
			dest_q      <= 1'b0;
			byte_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					tld_pkg::CFG_RUNNING: cfg_q.running <= cfg_data[0];
					tld_pkg::CFG_LINE_MODE: begin
						cfg_q.line_mode <= cfg_data[0];
						fill_q          <= '0;
					end
					tld_pkg::CFG_IN_CR_TO_LF: cfg_q.in_cr_to_lf <= cfg_data[0];
					tld_pkg::CFG_IN_LF_TO_CR: cfg_q.in_lf_to_cr <= cfg_data[0];
					tld_pkg::CFG_DEL_IS_BACKSPACE: cfg_q.del_is_backspace <= cfg_data[0];
					tld_pkg::CFG_OUT_NEWLINE_MODE: cfg_q.out_newline_mode <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						echo_q   <= act;
						idx_q    <= '0;
						len_q    <= fill_next;
						rd_idx_q <= '0;
						fill_q   <= act.flush ? '0 : fill_next;
						if (act.cnt != 2'd0) begin
							state_q <= ST_ECHO;
						end else if (act.flush) begin
							state_q <= ST_FL_RD;
						end
					end
				end
				ST_ECHO: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						dest_q      <= echo_q.dest;
						byte_q      <= echo_q.bytes[idx_q];
						last_q      <= (idx_q == echo_q.cnt - 2'd1) && !echo_q.flush;
						idx_q       <= idx_q + 2'd1;
						if (idx_q == echo_q.cnt - 2'd1) begin
							state_q <= echo_q.flush ? ST_FL_RD : ST_IDLE;
						end
					end
				end
				ST_FL_RD: begin
					state_q <= ST_FL_WT;
				end
				ST_FL_WT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						dest_q      <= tld_pkg::DEST_READER;
						byte_q      <= ram_rdata;
						last_q      <= fl_last;
						if (fl_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// between requests the line never sits at the flush threshold
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q != AW'(BUFFER_DEPTH - 1)))
		else $error("line fill at flush threshold while idle");

	// the line ram is only written when a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("line ram written outside idle");

	// a flush always reads inside the stored line
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FL_WT) |-> (rd_idx_q < len_q))
		else $error("flush read beyond stored line");

	// the flush wait state follows a ram read in the cycle before, or continues itself
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FL_WT) |-> ($past(ram_re) || $past(state_q) == ST_FL_WT))
		else $error("flush output without ram read");

endmodule

// ===== rtl/tld_ram.sv =====
// tld_ram: generic single write, single read ram with registered read data
// no dependencies

module tld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tld_decode.sv =====
// tld_decode: key translation, echo sequence and fill count update for one request
// depends on tld_pkg

module tld_decode #(
	parameter int BUFFER_DEPTH = tld_pkg::BUFFER_DEPTH
) (
	input  logic                            kind,
	input  logic [7:0]                      char_byte,
	input  tld_pkg::tld_cfg_t               cfg,
	input  logic [$clog2(BUFFER_DEPTH)-1:0] fill,
	output tld_pkg::tld_echo_t              act,
	output logic [$clog2(BUFFER_DEPTH)-1:0] fill_next
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [7:0] c;
	logic       erase;

	always_comb begin
		c = char_byte;
		if (char_byte == tld_pkg::CH_CR && cfg.in_cr_to_lf) begin
			c = tld_pkg::CH_LF;
		end else if (char_byte == tld_pkg::CH_LF && cfg.in_lf_to_cr) begin
			c = tld_pkg::CH_CR;
		end
	end

	assign erase = (c == tld_pkg::CH_BS) || (c == tld_pkg::CH_DEL && cfg.del_is_backspace);

	always_comb begin
		act       = '0;
		act.ch    = c;
		fill_next = fill;
		if (!cfg.running) begin
			act.cnt = 2'd0;
		end else if (kind) begin
			act = tld_pkg::screen_seq(char_byte, cfg.out_newline_mode);
		end else if (!cfg.line_mode) begin
			act.bytes[0] = c;
			act.cnt      = 2'd1;
			act.dest     = tld_pkg::DEST_READER;
		end else begin
			if (erase) begin
				if (fill != '0) begin
					fill_next    = fill - AW'(1);
					act.bytes[0] = tld_pkg::CH_BS;
					act.bytes[1] = tld_pkg::CH_SPACE;
					act.bytes[2] = tld_pkg::CH_BS;
					act.cnt      = 2'd3;
					act.dest     = tld_pkg::DEST_SCREEN;
				end
			end else if (c != tld_pkg::CH_DEL) begin
				act       = tld_pkg::screen_seq(c, cfg.out_newline_mode);
				act.store = 1'b1;
				fill_next = fill + AW'(1);
			end
			act.ch    = c;
			act.flush = (c == tld_pkg::CH_LF) || (fill_next == AW'(BUFFER_DEPTH - 1));
		end
	end

endmodule
